// ===== rtl/core/modbus_rtu_coil_framer_unit_macros.svh =====
// Assertion macros shared by the coil framer RTL.
// Included by the modules that check their own logic; needs nothing else.
`ifndef MODBUS_RTU_COIL_FRAMER_UNIT_MACROS_SVH
`define MODBUS_RTU_COIL_FRAMER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under the synchronous reset.
`define MBCF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the synchronous reset.
`define MBCF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MBCF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define MBCF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/mbcf_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the coil framer.
// No dependencies; every RTL module of the block imports it.
package mbcf_pkg;

  localparam int RX_BUFFER_BYTES_DEF = 32;
  localparam int HEAD_BYTES          = 4;
  localparam int CMD_FIFO_DEPTH      = 2;

  localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;
  localparam logic [7:0]  FUNC_WRITE_COIL     = 8'h05;
  localparam logic [7:0]  FUNC_READ_COILS     = 8'h01;
  localparam logic [15:0] VALUE_COIL_ON       = 16'hFF00;
  localparam logic [15:0] VALUE_COIL_OFF      = 16'h0000;
  localparam logic [15:0] READ_QUANTITY       = 16'h0001;
  localparam logic [7:0]  EXCEPTION_BIT       = 8'h80;

  // Kind of an outgoing beat.
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Byte positions within a request frame.
  localparam logic [2:0] BYTE_ADDR    = 3'd0;
  localparam logic [2:0] BYTE_FUNC    = 3'd1;
  localparam logic [2:0] BYTE_COIL_HI = 3'd2;
  localparam logic [2:0] BYTE_COIL_LO = 3'd3;
  localparam logic [2:0] BYTE_VAL_HI  = 3'd4;
  localparam logic [2:0] BYTE_VAL_LO  = 3'd5;
  localparam logic [2:0] BYTE_CRC_LO  = 3'd6;
  localparam logic [2:0] BYTE_CRC_HI  = 3'd7;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_RESP  = 2'd2
  } mbcf_mode_t;

  typedef enum logic [1:0] {
    COIL_OFF   = 2'd0,
    COIL_ON    = 2'd1,
    COIL_FAULT = 2'd2
  } mbcf_coil_state_t;

  // One unit of work for the back end: a request frame or a verdict.
  typedef struct packed {
    logic             is_verdict;
    logic             is_write;
    logic [7:0]       addr;
    logic [15:0]      coil;
    logic             coil_on;
    mbcf_coil_state_t verdict;
  } mbcf_cmd_t;

  // CRC-16/MODBUS over one byte, reflected polynomial.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mbcf_front.sv =====
// Front end of the coil framer: takes input beats, tracks the response bytes
// and their CRC, and queues request and verdict commands. Uses mbcf_pkg.
`include "modbus_rtu_coil_framer_unit_macros.svh"

module mbcf_front #(
  parameter int RX_BUFFER_BYTES = mbcf_pkg::RX_BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_slave_address,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [15:0]         in_coil_address,
  input  logic                in_coil_on,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_rx_last,
  output logic                push_valid,
  input  logic                push_ready,
  output mbcf_pkg::mbcf_cmd_t push_cmd
);
  import mbcf_pkg::*;

  localparam int CNT_W = $clog2(RX_BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] BUF_LIMIT    = CNT_W'(RX_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] MIN_LEN_CRC  = CNT_W'(5);
  localparam logic [CNT_W-1:0] MIN_LEN_DATA = CNT_W'(6);

  logic [7:0]       slave_address_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      hist0_r, hist0_nxt;
  logic [15:0]      hist1_r, hist1_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       head_r   [HEAD_BYTES];
  logic [7:0]       head_nxt [HEAD_BYTES];
  logic [7:0]       tail0_r, tail0_nxt;
  logic [7:0]       tail1_r, tail1_nxt;

  logic             acc;
  logic             store;
  mbcf_mode_t       mode;
  logic [CNT_W-1:0] st_count;
  logic [15:0]      st_crc, st_hist0, st_hist1;
  logic [7:0]       st_tail0, st_tail1;
  logic [7:0]       st_head [HEAD_BYTES];
  mbcf_coil_state_t verdict;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign acc       = in_valid && in_ready;
  assign mode      = mbcf_mode_t'(in_mode);
  assign store     = count_r < BUF_LIMIT;

  // Receive state as it stands once the current byte is stored.
  always_comb begin
    st_count = store ? count_r + 1'b1 : count_r;
    st_crc   = store ? crc_update(crc_r, in_rx_byte) : crc_r;
    st_hist0 = store ? crc_r : hist0_r;
    st_hist1 = store ? hist0_r : hist1_r;
    st_tail0 = store ? tail1_r : tail0_r;
    st_tail1 = store ? in_rx_byte : tail1_r;
    for (int k = 0; k < HEAD_BYTES; k++) begin
      st_head[k] = (store && count_r == CNT_W'(k)) ? in_rx_byte : head_r[k];
    end
  end

  // Response checks, first failure gives a fault.
  always_comb begin
    if (st_count < MIN_LEN_CRC) begin
      verdict = COIL_FAULT;
    end else if ({st_tail1, st_tail0} != st_hist1) begin
      verdict = COIL_FAULT;
    end else if (st_head[0] != slave_address_r) begin
      verdict = COIL_FAULT;
    end else if ((st_head[1] & EXCEPTION_BIT) != 8'h00) begin
      verdict = COIL_FAULT;
    end else if (st_head[1] != FUNC_READ_COILS) begin
      verdict = COIL_FAULT;
    end else if (st_count < MIN_LEN_DATA) begin
      verdict = COIL_FAULT;
    end else if (st_head[2] == 8'h00) begin
      verdict = COIL_FAULT;
    end else begin
      verdict = st_head[3][0] ? COIL_ON : COIL_OFF;
    end
  end

  // Next receive state and the command handed to the queue.
  always_comb begin
    crc_nxt   = crc_r;
    hist0_nxt = hist0_r;
    hist1_nxt = hist1_r;
    count_nxt = count_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;
    for (int k = 0; k < HEAD_BYTES; k++) begin
      head_nxt[k] = head_r[k];
    end
    push_valid          = 1'b0;
    push_cmd.is_verdict = 1'b0;
    push_cmd.is_write   = (mode == MODE_WRITE);
    push_cmd.addr       = slave_address_r;
    push_cmd.coil       = in_coil_address;
    push_cmd.coil_on    = in_coil_on;
    push_cmd.verdict    = verdict;

    if (acc) begin
      case (mode)
        MODE_WRITE, MODE_READ: begin
          push_valid = 1'b1;
          crc_nxt    = CRC_INIT;
          hist0_nxt  = CRC_INIT;
          hist1_nxt  = CRC_INIT;
          count_nxt  = '0;
          tail0_nxt  = 8'h00;
          tail1_nxt  = 8'h00;
          for (int k = 0; k < HEAD_BYTES; k++) begin
            head_nxt[k] = 8'h00;
          end
        end
        MODE_RESP: begin
          if (in_rx_last) begin
            push_valid          = 1'b1;
            push_cmd.is_verdict = 1'b1;
            crc_nxt   = CRC_INIT;
            hist0_nxt = CRC_INIT;
            hist1_nxt = CRC_INIT;
            count_nxt = '0;
            tail0_nxt = 8'h00;
            tail1_nxt = 8'h00;
            for (int k = 0; k < HEAD_BYTES; k++) begin
              head_nxt[k] = 8'h00;
            end
          end else begin
            crc_nxt   = st_crc;
            hist0_nxt = st_hist0;
            hist1_nxt = st_hist1;
            count_nxt = st_count;
            tail0_nxt = st_tail0;
            tail1_nxt = st_tail1;
            for (int k = 0; k < HEAD_BYTES; k++) begin
              head_nxt[k] = st_head[k];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration and receive state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= SLAVE_ADDRESS_RESET;
      crc_r           <= CRC_INIT;
      hist0_r         <= CRC_INIT;
      hist1_r         <= CRC_INIT;
      count_r         <= '0;
      tail0_r         <= 8'h00;
      tail1_r         <= 8'h00;
      for (int k = 0; k < HEAD_BYTES; k++) begin
        head_r[k] <= 8'h00;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        slave_address_r <= cfg_slave_address;
      end
      crc_r   <= crc_nxt;
      hist0_r <= hist0_nxt;
      hist1_r <= hist1_nxt;
      count_r <= count_nxt;
      tail0_r <= tail0_nxt;
      tail1_r <= tail1_nxt;
      for (int k = 0; k < HEAD_BYTES; k++) begin
        head_r[k] <= head_nxt[k];
      end
    end
  end

  `MBCF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= BUF_LIMIT, "receive count past buffer size")
  `MBCF_ASSERT_NXT(a_clear_after_verdict, clk, rst_n, acc && mode == MODE_RESP && in_rx_last, count_r == '0 && crc_r == CRC_INIT, "receive state not cleared after verdict")
  `MBCF_ASSERT_NXT(a_count_step, clk, rst_n, acc && mode == MODE_RESP && !in_rx_last && store, count_r == $past(count_r) + 1'b1, "stored byte not counted")

endmodule

// ===== rtl/core/mbcf_cmd_fifo.sv =====
// Short command queue between the front and back ends of the coil framer.
// Uses mbcf_pkg for the command type and the queue depth.
module mbcf_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  mbcf_pkg::mbcf_cmd_t push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mbcf_pkg::mbcf_cmd_t pop_cmd
);
  import mbcf_pkg::*;

  localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_FIFO_DEPTH);

  mbcf_cmd_t        slot_r [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != CNT_FULL;
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/mbcf_back.sv =====
// Back end of the coil framer: turns queued commands into output beats,
// eight frame bytes with a running CRC per request, one beat per verdict.
// Uses mbcf_pkg.
`include "modbus_rtu_coil_framer_unit_macros.svh"

module mbcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  mbcf_pkg::mbcf_cmd_t head_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_result_kind,
  output logic [7:0]          out_frame_byte,
  output logic                out_last,
  output logic [1:0]          out_coil_state
);
  import mbcf_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_frame_byte_r, out_frame_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [1:0]  out_coil_state_r, out_coil_state_nxt;

  logic        slot_free;
  logic        fire;
  logic [7:0]  frame_byte;
  logic [15:0] crc_base;

  assign slot_free = !out_valid_r || out_ready;
  assign fire      = pop_valid && slot_free;
  assign pop_ready = fire && (head_cmd.is_verdict || idx_r == BYTE_CRC_HI);

  // Frame byte at the current position.
  always_comb begin
    case (idx_r)
      BYTE_ADDR:    frame_byte = head_cmd.addr;
      BYTE_FUNC:    frame_byte = head_cmd.is_write ? FUNC_WRITE_COIL : FUNC_READ_COILS;
      BYTE_COIL_HI: frame_byte = head_cmd.coil[15:8];
      BYTE_COIL_LO: frame_byte = head_cmd.coil[7:0];
      BYTE_VAL_HI: begin
        if (head_cmd.is_write) begin
          frame_byte = head_cmd.coil_on ? VALUE_COIL_ON[15:8] : VALUE_COIL_OFF[15:8];
        end else begin
          frame_byte = READ_QUANTITY[15:8];
        end
      end
      BYTE_VAL_LO: begin
        if (head_cmd.is_write) begin
          frame_byte = head_cmd.coil_on ? VALUE_COIL_ON[7:0] : VALUE_COIL_OFF[7:0];
        end else begin
          frame_byte = READ_QUANTITY[7:0];
        end
      end
      BYTE_CRC_LO:  frame_byte = crc_r[7:0];
      BYTE_CRC_HI:  frame_byte = crc_r[15:8];
      default:      frame_byte = 8'h00;
    endcase
  end

  // Sequencer and output register.
  always_comb begin
    crc_base           = (idx_r == BYTE_ADDR) ? CRC_INIT : crc_r;
    idx_nxt            = idx_r;
    crc_nxt            = crc_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_kind_nxt       = out_kind_r;
    out_frame_byte_nxt = out_frame_byte_r;
    out_last_nxt       = out_last_r;
    out_coil_state_nxt = out_coil_state_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (head_cmd.is_verdict) begin
        out_kind_nxt       = KIND_VERDICT;
        out_frame_byte_nxt = 8'h00;
        out_last_nxt       = 1'b1;
        out_coil_state_nxt = head_cmd.verdict;
      end else begin
        out_kind_nxt       = KIND_FRAME;
        out_frame_byte_nxt = frame_byte;
        out_last_nxt       = (idx_r == BYTE_CRC_HI);
        out_coil_state_nxt = COIL_OFF;
        idx_nxt            = idx_r + 1'b1;
        if (idx_r < BYTE_CRC_LO) begin
          crc_nxt = crc_update(crc_base, frame_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= BYTE_ADDR;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload; no reset needed.
  always_ff @(posedge clk) begin
    out_kind_r       <= out_kind_nxt;
    out_frame_byte_r <= out_frame_byte_nxt;
    out_last_r       <= out_last_nxt;
    out_coil_state_r <= out_coil_state_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_frame_byte  = out_frame_byte_r;
  assign out_last        = out_last_r;
  assign out_coil_state  = out_coil_state_r;

  `MBCF_ASSERT_IMP(a_mid_frame_is_request, clk, rst_n, idx_r != BYTE_ADDR, pop_valid && !head_cmd.is_verdict, "frame position set without a request at queue head")
  `MBCF_ASSERT_IMP(a_verdict_shape, clk, rst_n, out_valid_r && out_kind_r == KIND_VERDICT, out_frame_byte_r == 8'h00 && out_last_r, "verdict beat with frame byte or without last")
  `MBCF_ASSERT_NXT(a_frame_wraps, clk, rst_n, fire && !head_cmd.is_verdict && idx_r == BYTE_CRC_HI, idx_r == BYTE_ADDR && out_last_r, "frame did not end on eighth byte")

endmodule

// ===== rtl/core/modbus_rtu_coil_framer_unit.sv =====
// Top level of the Modbus RTU single-coil framer.
// Depends on mbcf_pkg, mbcf_front, mbcf_cmd_fifo and mbcf_back.

// A write or read request produces eight frame beats (address, function, coil,
// value or quantity, CRC low, CRC high); the back end sends one byte per cycle
// while out_ready holds and a request is queued, from its byte sequencer and
// its one-byte-per-cycle CRC unit. Response bytes are taken one per cycle while
// the command queue has room; the byte marked last yields a single verdict beat
// (off, on or fault) that is valid on the output from the edge at which the
// queue hands it over; it passes through the command queue and then the
// output register. The first frame byte of a request takes the same path. A
// two-entry command queue separates the input side from the output side, so
// input beats keep flowing while frame bytes wait on out_ready, until the
// queue fills. Bytes past RX_BUFFER_BYTES are dropped. The slave address
// register resets to 1 and should be written only while the block is idle.
module modbus_rtu_coil_framer_unit #(
  parameter int RX_BUFFER_BYTES = mbcf_pkg::RX_BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_slave_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_coil_address,
  input  logic        in_coil_on,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_frame_byte,
  output logic        out_last,
  output logic [1:0]  out_coil_state
);
  import mbcf_pkg::*;

  logic      push_valid, push_ready;
  mbcf_cmd_t push_cmd;
  logic      pop_valid, pop_ready;
  mbcf_cmd_t pop_cmd;

  // Input side: classification and receive tracking.
  mbcf_front #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_slave_address (cfg_slave_address),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_coil_address   (in_coil_address),
    .in_coil_on        (in_coil_on),
    .in_rx_byte        (in_rx_byte),
    .in_rx_last        (in_rx_last),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_cmd          (push_cmd)
  );

  // Command queue.
  mbcf_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Output side: frame sequencing and verdict beats.
  mbcf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .head_cmd        (pop_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_frame_byte  (out_frame_byte),
    .out_last        (out_last),
    .out_coil_state  (out_coil_state)
  );

endmodule
